// ===== rtl/cru_pkg.sv =====
// ----------------------------------------------------------------------------
// Catmull-Rom upsampler package
// Register indexes, configuration limits and the command flags that the
// front end hands to the evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cru_pkg;

  localparam int unsigned PB_BITS = 6;

  localparam logic [0:0] REG_POINTS_BETWEEN = 1'b0;
  localparam logic [0:0] REG_U_STEP         = 1'b1;

  localparam logic [PB_BITS-1:0] PB_RESET    = 6'd7;
  localparam logic [PB_BITS-1:0] MAX_BETWEEN = 6'd62;

  typedef struct packed {
    logic               seg;
    logic               close;
    logic [PB_BITS-1:0] n;
  } cmd_flags_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD,
    ST_ROUND,
    ST_CLOSE
  } back_state_e;

endpackage

`default_nettype wire

// ===== rtl/catmull_rom_upsampler.sv =====
// ----------------------------------------------------------------------------
// Catmull-Rom upsampler
// Streams signed samples and emits the points of the uniform Catmull-Rom
// segment between the two middle samples of a sliding window.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                 payload
//   s_axis    in         s_axis_tvalid/tready      tdata: sample, tlast: end_of_run
//   m_axis    out        m_axis_tvalid/tready      tdata: point, tlast: last_point
//   cfg       in         cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
// A sample word is taken whenever the two-entry command queue has room. Each
// point of a segment is evaluated in three Horner steps of two half-width
// multiplies and one add, followed by a rounding step. A segment has n+1
// points, eight at reset values, and a closing point may follow at the end of
// a run. Output stalls hold the evaluator, and the input stalls once the queue
// is full; reset clears window and queue.
//
`default_nettype none

module catmull_rom_upsampler #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned U_FRAC_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // Fields from bit 0: sample.
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  input  wire logic                                 s_axis_tlast,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // Fields from bit 0: point.
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]          m_axis_tdata,
  output logic                                      m_axis_tlast,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [0:0]                           cfg_index_i,
  input  wire logic [U_FRAC_BITS:0]                 cfg_data_i
);

  import cru_pkg::*;

  localparam int unsigned TDW = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned CW  = SAMPLE_BITS + 5;
  localparam int unsigned DW  = 4 * CW + SAMPLE_BITS;
  localparam int unsigned QW  = $bits(cmd_flags_t) + DW;

  localparam logic [U_FRAC_BITS:0] U_STEP_RESET = (U_FRAC_BITS + 1)'(1) << (U_FRAC_BITS - 3);

  logic [PB_BITS-1:0]     pb_q;
  logic [U_FRAC_BITS:0]   ustep_q;
  logic                   push, full, pop, empty;
  cmd_flags_t             push_flags, pop_flags;
  logic [DW-1:0]          push_data, pop_data;
  logic [QW-1:0]          q_out;
  logic [SAMPLE_BITS-1:0] point;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_q    <= PB_RESET;
      ustep_q <= U_STEP_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_POINTS_BETWEEN) begin
        pb_q <= cfg_data_i[PB_BITS-1:0];
      end
      if (cfg_index_i == REG_U_STEP) begin
        ustep_q <= cfg_data_i;
      end
    end
  end

  cru_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .sample_i        ($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
    .end_of_run_i    (s_axis_tlast),
    .points_between_i(pb_q),
    .full_i          (full),
    .push_o          (push),
    .flags_o         (push_flags),
    .data_o          (push_data)
  );

  cru_fifo #(
    .WIDTH(QW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({push_flags, push_data}),
    .full_o (full),
    .pop_i  (pop),
    .data_o (q_out),
    .empty_o(empty)
  );

  assign pop_flags = q_out[QW-1:DW];
  assign pop_data  = q_out[DW-1:0];

  cru_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .U_FRAC_BITS(U_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .flags_i     (pop_flags),
    .data_i      (pop_data),
    .pop_o       (pop),
    .u_step_i    (ustep_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .point_o     (point),
    .last_point_o(m_axis_tlast)
  );

  assign m_axis_tdata = TDW'(point);

endmodule

`default_nettype wire

// ===== rtl/cru_fifo.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue between the sample front end and the segment evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

module cru_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cru_front.sv =====
// ----------------------------------------------------------------------------
// Sample front end
// Keeps the three-sample window, classifies each incoming word and builds
// the segment coefficients and closing value for the evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

module cru_front #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0]   sample_i,
  input  wire logic                            end_of_run_i,
  input  wire logic [cru_pkg::PB_BITS-1:0]     points_between_i,
  input  wire logic                            full_i,
  output logic                                 push_o,
  output cru_pkg::cmd_flags_t                  flags_o,
  output logic [4*(SAMPLE_BITS+5)+SAMPLE_BITS-1:0] data_o
);

  import cru_pkg::*;

  localparam int unsigned CW = SAMPLE_BITS + 5;

  logic signed [SAMPLE_BITS-1:0] win_q [3];
  logic signed [SAMPLE_BITS-1:0] win_d [3];
  logic [1:0]                    seen_q, seen_d;
  logic                          accept;
  logic signed [CW-1:0]          e0, e1, e2, e3;
  logic signed [CW-1:0]          coef_a, coef_b, coef_c, coef_d;
  logic [PB_BITS-1:0]            n_clamped;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign e0 = CW'(win_q[0]);
  assign e1 = CW'(win_q[1]);
  assign e2 = CW'(win_q[2]);
  assign e3 = CW'(sample_i);

  assign coef_a = (e1 + (e1 <<< 1)) - (e2 + (e2 <<< 1)) + e3 - e0;
  assign coef_b = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
  assign coef_c = e2 - e0;
  assign coef_d = e1 <<< 1;

  assign n_clamped = (points_between_i > MAX_BETWEEN) ? MAX_BETWEEN : points_between_i;

  assign flags_o.seg   = (seen_q == 2'd3);
  assign flags_o.close = end_of_run_i && (seen_q >= 2'd2);
  assign flags_o.n     = n_clamped;
  assign data_o        = {win_q[2], coef_d, coef_c, coef_b, coef_a};
  assign push_o        = accept && (flags_o.seg || flags_o.close);

  always_comb begin
    win_d  = win_q;
    seen_d = seen_q;
    if (accept) begin
      if (end_of_run_i) begin
        win_d[0] = '0;
        win_d[1] = '0;
        win_d[2] = '0;
        seen_d   = 2'd0;
      end else begin
        win_d[0] = win_q[1];
        win_d[1] = win_q[2];
        win_d[2] = sample_i;
        if (seen_q != 2'd3) begin
          seen_d = seen_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q[0] <= '0;
      win_q[1] <= '0;
      win_q[2] <= '0;
      seen_q   <= 2'd0;
    end else begin
      win_q  <= win_d;
      seen_q <= seen_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cru_back.sv =====
// ----------------------------------------------------------------------------
// Segment evaluator
// Walks the points of one segment, evaluating the cubic by Horner steps on a
// shared half-width multiplier, then rounds, saturates and emits each point.
// ----------------------------------------------------------------------------
`default_nettype none

module cru_back #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned U_FRAC_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            empty_i,
  input  wire cru_pkg::cmd_flags_t             flags_i,
  input  wire logic [4*(SAMPLE_BITS+5)+SAMPLE_BITS-1:0] data_i,
  output logic                                 pop_o,
  input  wire logic [U_FRAC_BITS:0]            u_step_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [SAMPLE_BITS-1:0]               point_o,
  output logic                                 last_point_o
);

  import cru_pkg::*;

  localparam int unsigned S   = SAMPLE_BITS;
  localparam int unsigned F   = U_FRAC_BITS;
  localparam int unsigned CW  = S + 5;
  localparam int unsigned DW  = 4 * CW + S;
  localparam int unsigned AW  = S + F + 5;
  localparam int unsigned HW  = AW / 2;
  localparam int unsigned LW  = AW - HW;
  localparam int unsigned MW  = LW + 1;
  localparam int unsigned UMW = F + 2;
  localparam int unsigned PW  = MW + UMW;
  localparam int unsigned SW  = AW + F + 2;
  localparam int unsigned RW  = AW - F - 1;

  localparam logic        [F+1:0] ONE_U   = (F + 2)'(1) << F;
  localparam logic signed [AW-1:0] ONE_ACC = AW'(1) << F;
  localparam logic signed [RW-1:0] PMAX    = RW'((64'sd1 <<< (S - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] PMIN    = RW'(-(64'sd1 <<< (S - 1)));

  back_state_e           state_q, state_d;
  cmd_flags_t            flags_q, flags_d;
  logic [DW-1:0]         data_q, data_d;
  logic [PB_BITS-1:0]    j_q, j_d;
  logic [F:0]            u_q, u_d;
  logic [1:0]            hstep_q, hstep_d;
  logic signed [AW-1:0]  acc_q, acc_d;
  logic signed [PW-1:0]  plo_q, phi_q;
  logic                  ovalid_q, ovalid_d;
  logic [S-1:0]          odata_q, odata_d;
  logic                  olast_q, olast_d;

  logic signed [CW-1:0]  coef_a, coef_b, coef_c, coef_d, coef_sel;
  logic signed [CW-1:0]  ld_a;
  logic signed [S-1:0]   close_val;
  logic signed [MW-1:0]  mul_a;
  logic signed [UMW-1:0] mul_b;
  logic signed [PW-1:0]  mul_p;
  logic signed [SW-1:0]  sum;
  logic signed [AW-1:0]  rsum;
  logic signed [RW-1:0]  rsh;
  logic [S-1:0]          rsat;
  logic [F+1:0]          usum;
  logic                  out_free;

  assign coef_a    = data_q[CW-1:0];
  assign coef_b    = data_q[2*CW-1:CW];
  assign coef_c    = data_q[3*CW-1:2*CW];
  assign coef_d    = data_q[4*CW-1:3*CW];
  assign close_val = data_q[DW-1:4*CW];
  assign ld_a      = data_i[CW-1:0];

  assign out_free     = !ovalid_q || out_ready_i;
  assign out_valid_o  = ovalid_q;
  assign point_o      = odata_q;
  assign last_point_o = olast_q;

  always_comb begin
    case (hstep_q)
      2'd0:    coef_sel = coef_b;
      2'd1:    coef_sel = coef_c;
      default: coef_sel = coef_d;
    endcase
  end

  assign mul_a = (state_q == ST_MUL_LO) ? $signed({1'b0, acc_q[LW-1:0]})
                                        : MW'($signed(acc_q[AW-1:LW]));
  assign mul_b = $signed({1'b0, u_q});
  assign mul_p = mul_a * mul_b;

  assign sum = (SW'(phi_q) <<< LW) + SW'(plo_q) + (SW'(coef_sel) <<< (2 * F));

  assign rsum = acc_q + ONE_ACC;
  assign rsh  = RW'(rsum >>> (F + 1));
  always_comb begin
    if (rsh > PMAX) begin
      rsat = PMAX[S-1:0];
    end else if (rsh < PMIN) begin
      rsat = PMIN[S-1:0];
    end else begin
      rsat = rsh[S-1:0];
    end
  end

  assign usum = {1'b0, u_q} + {1'b0, u_step_i};

  always_comb begin
    state_d  = state_q;
    flags_d  = flags_q;
    data_d   = data_q;
    j_d      = j_q;
    u_d      = u_q;
    hstep_d  = hstep_q;
    acc_d    = acc_q;
    ovalid_d = ovalid_q && !out_ready_i;
    odata_d  = odata_q;
    olast_d  = olast_q;
    pop_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          flags_d = flags_i;
          data_d  = data_i;
          j_d     = '0;
          u_d     = '0;
          hstep_d = 2'd0;
          acc_d   = AW'(ld_a) <<< F;
          state_d = flags_i.seg ? ST_MUL_LO : ST_CLOSE;
        end
      end
      ST_MUL_LO: begin
        state_d = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        state_d = ST_ADD;
      end
      ST_ADD: begin
        acc_d = AW'(sum >>> F);
        if (hstep_q == 2'd2) begin
          state_d = ST_ROUND;
        end else begin
          hstep_d = hstep_q + 2'd1;
          state_d = ST_MUL_LO;
        end
      end
      ST_ROUND: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          odata_d  = rsat;
          olast_d  = 1'b0;
          if (j_q == flags_q.n) begin
            state_d = flags_q.close ? ST_CLOSE : ST_IDLE;
          end else begin
            j_d     = j_q + 1'b1;
            u_d     = (usum > ONE_U) ? ONE_U[F:0] : usum[F:0];
            hstep_d = 2'd0;
            acc_d   = AW'(coef_a) <<< F;
            state_d = ST_MUL_LO;
          end
        end
      end
      ST_CLOSE: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          odata_d  = close_val;
          olast_d  = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flags_q <= flags_d;
    data_q  <= data_d;
    j_q     <= j_d;
    u_q     <= u_d;
    hstep_q <= hstep_d;
    acc_q   <= acc_d;
    odata_q <= odata_d;
    olast_q <= olast_d;
    if (state_q == ST_MUL_LO) begin
      plo_q <= mul_p;
    end
    if (state_q == ST_MUL_HI) begin
      phi_q <= mul_p;
    end
  end

endmodule

`default_nettype wire
